@@ src/scr_pkg.sv @@
// Shared definitions for the execute core: opcodes, error codes, widths
// and the immediate shaping function. No dependencies.
`timescale 1ns / 1ps

package scr_pkg;

   localparam int DATA_WORDS_DEF = 4096;
   localparam int RET_DEPTH_DEF  = 16;
   localparam int PC_W           = 26;
   localparam int WORD_W         = 32;
   localparam int MADDR_W        = 12;
   localparam int RSP_W          = 120;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_DIV  = 5'd3,
      OP_MOD  = 5'd4,
      OP_CMP  = 5'd5,
      OP_AND  = 5'd6,
      OP_OR   = 5'd7,
      OP_NOT  = 5'd8,
      OP_MOV  = 5'd9,
      OP_LSL  = 5'd10,
      OP_LSR  = 5'd11,
      OP_ASR  = 5'd12,
      OP_NOP  = 5'd13,
      OP_LD   = 5'd14,
      OP_ST   = 5'd15,
      OP_BEQ  = 5'd16,
      OP_BGT  = 5'd17,
      OP_B    = 5'd18,
      OP_CALL = 5'd19,
      OP_RET  = 5'd20,
      OP_HLT  = 5'd21
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_STACK  = 2'd1,
      ERR_DIV0   = 2'd2,
      ERR_OPCODE = 2'd3
   } err_type;

   localparam logic [1:0] IMM_SEXT = 2'b00;
   localparam logic [1:0] IMM_HIGH = 2'b10;

   typedef struct packed {
      logic start;
      logic want_rem;
      logic is_unsigned;
   } div_ctl_type;

   function automatic logic [WORD_W-1:0] shape_imm(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      case (w[17:16])
         IMM_SEXT: r = {{16{w[15]}}, w[15:0]};
         IMM_HIGH: r = {w[15:0], 16'd0};
         default:  r = {16'd0, w[15:0]};
      endcase
      return r;
   endfunction

endpackage

@@ src/simplerisc_execute_core.sv @@
// Execute core top level: sequencer, register file, data memory, return stack.
// Depends on scr_pkg and scr_div.
//
//   channel | dir | beat contents
//   req_    | in  | instruction word
//   rsp_    | out | next PC, write-back, store, flags, error
//
// Stores take a memory step, loads a memory and a load step; when DATA_WORDS
// is not a power of two the address wrap goes through the divider, as div/mod
// do. Reset: a clearing pass writes zeros to all DATA_WORDS words of data
// memory, with req_tready low. One instruction is in flight at a time; the
// next one is taken while the previous result still waits on rsp_tready.
`timescale 1ns / 1ps

module simplerisc_execute_core #(
   parameter int DATA_WORDS      = scr_pkg::DATA_WORDS_DEF,
   parameter int RET_STACK_DEPTH = scr_pkg::RET_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,  // [31:0] instruction
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [25:0] next_pc, [26] halted, [27] write_enable, [31:28] write_index,
   // [63:32] write_value, [64] store_enable, [76:65] mem_address,
   // [108:77] store_value, [109] equal_flag, [110] greater_flag,
   // [112:111] error_code, [119:113] zero
   output logic [scr_pkg::RSP_W-1:0] rsp_tdata
);
   import scr_pkg::*;

   localparam int  AW      = $clog2(DATA_WORDS);
   localparam bit  IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
   localparam int  SIW     = (RET_STACK_DEPTH > 1) ? $clog2(RET_STACK_DEPTH) : 1;
   localparam int  SCW     = $clog2(RET_STACK_DEPTH + 1);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_OPB   = 9'b000000100,
      ST_OPD   = 9'b000001000,
      ST_EXEC  = 9'b000010000,
      ST_DIV   = 9'b000100000,
      ST_MEM   = 9'b001000000,
      ST_LOAD  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [31:0]       instr_ff, a_ff, b_ff, wval_ff, sval_ff;
   logic              wr_ff, se_ff;
   err_type           err_ff;
   logic [AW-1:0]     addr_ff;
   logic [PC_W-1:0]   pc_ff;
   logic              eq_ff, gt_ff, halt_ff;
   logic [SCW-1:0]    stk_cnt_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic              wr_in, se_in;
   logic [31:0]       wval_in, sval_in;
   logic [AW-1:0]     addr_in;
   err_type           err_in;
   logic [PC_W-1:0]   pc_in;
   state_type         exec_state;

   logic [31:0]       rf_mem [16];
   logic [15:0]       rf_vld_ff;
   logic [31:0]       rf_q_ff;
   logic              rf_qv_ff;
   logic [3:0]        rf_addr;
   logic [31:0]       rf_val;

   logic [31:0]       dm_mem [DATA_WORDS];
   logic [31:0]       dm_q_ff;
   logic              dm_we;
   logic [AW-1:0]     dm_waddr;
   logic [31:0]       dm_wdata;

   logic [PC_W-1:0]   rs_mem [RET_STACK_DEPTH];
   logic [PC_W-1:0]   rs_q_ff;
   logic [SIW-1:0]    rs_raddr;
   logic              push;

   opcode_type        op;
   logic [PC_W-1:0]   pc_inc, target;
   logic [31:0]       sum, alu;
   logic              big_shift, out_go;
   logic [3:0]        rd;

   div_ctl_type       div_ctl;
   logic [31:0]       div_dividend, div_divisor, div_result;
   logic              div_done;

   assign op        = opcode_type'(instr_ff[31:27]);
   assign rd        = instr_ff[25:22];
   assign pc_inc    = pc_ff + 1'b1;
   assign target    = instr_ff[PC_W-1:0];
   assign sum       = a_ff + b_ff;
   assign big_shift = |b_ff[31:5];
   assign out_go    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (op)
         OP_ADD:  alu = a_ff + b_ff;
         OP_SUB:  alu = a_ff - b_ff;
         OP_MUL:  alu = a_ff * b_ff;
         OP_AND:  alu = a_ff & b_ff;
         OP_OR:   alu = a_ff | b_ff;
         OP_NOT:  alu = ~b_ff;
         OP_MOV:  alu = b_ff;
         OP_LSL:  alu = big_shift ? 32'd0 : (a_ff << b_ff[4:0]);
         OP_LSR:  alu = big_shift ? 32'd0 : (a_ff >> b_ff[4:0]);
         OP_ASR:  alu = big_shift ? {32{a_ff[31]}}
                                  : 32'($signed(a_ff) >>> b_ff[4:0]);
         default: alu = '0;
      endcase
   end

   // outcome of the execute step; a halted core leaves everything as it is
   always_comb begin
      wr_in      = 1'b0;
      se_in      = 1'b0;
      wval_in    = '0;
      sval_in    = '0;
      addr_in    = '0;
      err_in     = ERR_NONE;
      exec_state = ST_DONE;
      pc_in      = halt_ff ? pc_ff : pc_inc;
      if (!halt_ff) begin
         case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT, OP_MOV,
            OP_LSL, OP_LSR, OP_ASR: begin
               wr_in   = 1'b1;
               wval_in = alu;
            end
            OP_DIV, OP_MOD: begin
               wr_in = 1'b1;
               if (b_ff == 32'd0) err_in = ERR_DIV0;
               else exec_state = ST_DIV;
            end
            OP_CMP, OP_NOP: begin
            end
            OP_LD, OP_ST: begin
               wr_in   = (op == OP_LD);
               se_in   = (op == OP_ST);
               sval_in = (op == OP_ST) ? rf_val : 32'd0;
               if (IS_POW2) begin
                  addr_in    = sum[AW-1:0];
                  exec_state = ST_MEM;
               end else begin
                  exec_state = ST_DIV;
               end
            end
            OP_BEQ: if (eq_ff) pc_in = target;
            OP_BGT: if (gt_ff) pc_in = target;
            OP_B:   pc_in = target;
            OP_CALL: begin
               pc_in = target;
               if (!push) err_in = ERR_STACK;
            end
            OP_RET: if (stk_cnt_ff != '0) pc_in = rs_q_ff;
            OP_HLT: pc_in = pc_ff;
            default: err_in = ERR_OPCODE;
         endcase
      end
   end

   // register file port address follows the operand being fetched
   always_comb begin
      case (state_ff)
         ST_IDLE: rf_addr = req_tdata[21:18];
         ST_OPB:  rf_addr = instr_ff[17:14];
         default: rf_addr = rd;
      endcase
   end
   assign rf_val = rf_qv_ff ? rf_q_ff : 32'd0;

   assign div_ctl.start       = (state_ff == ST_EXEC) && !halt_ff &&
                                (((op == OP_DIV || op == OP_MOD) && b_ff != 32'd0) ||
                                 (!IS_POW2 && (op == OP_LD || op == OP_ST)));
   assign div_ctl.want_rem    = (op != OP_DIV);
   assign div_ctl.is_unsigned = (op == OP_LD || op == OP_ST);
   assign div_dividend        = div_ctl.is_unsigned ? sum : a_ff;
   assign div_divisor         = div_ctl.is_unsigned ? 32'(DATA_WORDS) : b_ff;

   scr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .result   (div_result)
   );

   assign push     = (state_ff == ST_EXEC) && !halt_ff && (op == OP_CALL) &&
                     (stk_cnt_ff < SCW'(RET_STACK_DEPTH));
   assign rs_raddr = SIW'(stk_cnt_ff - 1'b1);

   assign dm_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_MEM) && op == OP_ST);
   assign dm_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : addr_ff;
   assign dm_wdata = (state_ff == ST_CLEAR) ? 32'd0 : sval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         eq_ff        <= 1'b0;
         gt_ff        <= 1'b0;
         halt_ff      <= 1'b0;
         stk_cnt_ff   <= '0;
         rf_vld_ff    <= '0;
      end else begin
         if (state_ff == ST_DONE && out_go) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(DATA_WORDS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  instr_ff <= req_tdata;
                  state_ff <= ST_OPB;
               end
            end
            ST_OPB: begin
               a_ff     <= rf_val;
               state_ff <= ST_OPD;
            end
            ST_OPD: begin
               b_ff     <= instr_ff[26] ? shape_imm(instr_ff) : rf_val;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               wr_ff    <= wr_in;
               se_ff    <= se_in;
               wval_ff  <= wval_in;
               sval_ff  <= sval_in;
               addr_ff  <= addr_in;
               err_ff   <= err_in;
               pc_ff    <= pc_in;
               state_ff <= exec_state;
               if (!halt_ff) begin
                  case (op)
                     OP_CMP: begin
                        eq_ff <= (a_ff == b_ff);
                        gt_ff <= ($signed(a_ff) > $signed(b_ff));
                     end
                     OP_CALL: if (push) stk_cnt_ff <= stk_cnt_ff + 1'b1;
                     OP_RET:  if (stk_cnt_ff != '0) stk_cnt_ff <= stk_cnt_ff - 1'b1;
                     OP_HLT:  halt_ff <= 1'b1;
                     default: begin
                     end
                  endcase
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if (op == OP_LD || op == OP_ST) begin
                     addr_ff  <= div_result[AW-1:0];
                     state_ff <= ST_MEM;
                  end else begin
                     wval_ff  <= div_result;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_MEM: state_ff <= (op == OP_LD) ? ST_LOAD : ST_DONE;
            ST_LOAD: begin
               wval_ff  <= dm_q_ff;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_go) begin
                  rsp_data_ff  <= {7'd0, err_ff, gt_ff, eq_ff, sval_ff,
                                   MADDR_W'(addr_ff), se_ff, wval_ff,
                                   wr_ff ? rd : 4'd0, wr_ff, halt_ff, pc_ff};
                  if (wr_ff) rf_vld_ff[rd] <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_go && wr_ff) rf_mem[rd] <= wval_ff;
      rf_q_ff  <= rf_mem[rf_addr];
      rf_qv_ff <= rf_vld_ff[rf_addr];
   end

   always_ff @(posedge clock) begin
      if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
      dm_q_ff <= dm_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) rs_mem[stk_cnt_ff[SIW-1:0]] <= pc_inc;
      rs_q_ff <= rs_mem[rs_raddr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("instruction taken during memory clear");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_cnt_ff <= SCW'(RET_STACK_DEPTH))
      else $error("return stack count past depth");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt mark dropped");

   a_store_no_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[64]) |-> !rsp_tdata[27])
      else $error("store beat also reports write-back");

endmodule

@@ src/scr_div.sv @@
// Iterative divider, one quotient bit per cycle, signed or unsigned.
// Depends on scr_pkg.
`timescale 1ns / 1ps

module scr_div (
   input  logic                clock,
   input  logic                reset,
   input  scr_pkg::div_ctl_type div_ctl,
   input  logic [31:0]         dividend,
   input  logic [31:0]         divisor,
   output logic                done,
   output logic [31:0]         result
);
   import scr_pkg::*;

   logic        run_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] dq_ff, rem_ff, ub_ff;
   logic        neg_q_ff, neg_r_ff, rem_sel_ff;
   logic        na, nb;
   logic [32:0] shifted, diff;

   assign na      = !div_ctl.is_unsigned && dividend[31];
   assign nb      = !div_ctl.is_unsigned && divisor[31];
   assign shifted = {rem_ff, dq_ff[31]};
   assign diff    = shifted - {1'b0, ub_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && !div_ctl.start && (cnt_ff == 5'd31);
         if (div_ctl.start) begin
            run_ff     <= 1'b1;
            cnt_ff     <= '0;
            dq_ff      <= na ? (32'd0 - dividend) : dividend;
            ub_ff      <= nb ? (32'd0 - divisor) : divisor;
            rem_ff     <= '0;
            neg_q_ff   <= na ^ nb;
            neg_r_ff   <= na;
            rem_sel_ff <= div_ctl.want_rem;
         end else if (run_ff) begin
            // restoring step: keep the difference when it did not go negative
            rem_ff <= diff[32] ? shifted[31:0] : diff[31:0];
            dq_ff  <= {dq_ff[30:0], ~diff[32]};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) run_ff <= 1'b0;
         end
      end
   end

   assign done   = done_ff;
   assign result = rem_sel_ff ? (neg_r_ff ? (32'd0 - rem_ff) : rem_ff)
                              : (neg_q_ff ? (32'd0 - dq_ff) : dq_ff);

endmodule
